/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define WSFD_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WSFD_CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/wsfd_pkg.sv */
package wsfd_pkg;

    localparam int HOLD_DEPTH  = 10;
    localparam int MAX_RESULTS = 8;

    localparam logic [30:0] MAX_PAYLOAD_RESET = 31'd26214400;

    localparam logic [2:0] EV_DATA        = 3'd0;
    localparam logic [2:0] EV_PING        = 3'd1;
    localparam logic [2:0] EV_EMPTY_BIN   = 3'd2;
    localparam logic [2:0] EV_EMPTY_PING  = 3'd3;
    localparam logic [2:0] EV_UPGRADE_OK  = 3'd4;
    localparam logic [2:0] EV_UPGRADE_REJ = 3'd5;
    localparam logic [2:0] EV_CLOSE       = 3'd6;
    localparam logic [2:0] EV_RESYNC      = 3'd7;

    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [30:0] payload_length;
        logic        run_last;
    } t_out;

    typedef struct packed {
        logic load_in;
        logic step;
        logic first;
        logic p_load;
        logic o_load;
        logic o_last;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic more;
    } t_dp_stat;

    // Expected status line prefix, minor version digit checked separately.
    function automatic logic [7:0] reply_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            4'd4:    c = 8'h2f;
            4'd5:    c = 8'h31;
            4'd6:    c = 8'h2e;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h20;
            4'd9:    c = 8'h31;
            4'd10:   c = 8'h30;
            4'd11:   c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/wsfd_ctrl.sv */
module wsfd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  wsfd_pkg::t_dp_stat i_stat,
    output wsfd_pkg::t_dp_cmd  o_cmd
);
    import wsfd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PROC, S_FLUSH} t_state;

    t_state     r_state, n_state;
    logic       r_pv, n_pv;
    logic       r_ov, n_ov;
    logic       r_first, n_first;
    logic [3:0] r_cnt, n_cnt;
    logic       emit_ok;
    logic       o_free;

    assign emit_ok     = i_stat.emit && (r_cnt < 4'(MAX_RESULTS));
    assign o_free      = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    always_comb begin
        n_state = r_state;
        n_pv    = r_pv;
        n_ov    = r_ov;
        n_first = r_first;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.first = r_first;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_first = 1'b1;
                    n_cnt   = '0;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (!(emit_ok && r_pv && !o_free)) begin
                    o_cmd.step = 1'b1;
                    n_first = 1'b0;
                    if (emit_ok) begin
                        o_cmd.p_load = 1'b1;
                        n_pv  = 1'b1;
                        n_cnt = r_cnt + 4'd1;
                        if (r_pv) begin
                            o_cmd.o_load = 1'b1;
                            n_ov = 1'b1;
                        end
                    end
                    if (!i_stat.more) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (o_free) begin
                    o_cmd.o_load = 1'b1;
                    o_cmd.o_last = 1'b1;
                    n_ov    = 1'b1;
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* design/wsfd_dp.sv */
module wsfd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsfd_pkg::t_in      i_in,
    input  logic               i_cfg_valid,
    input  logic [30:0]        i_cfg_data,
    input  wsfd_pkg::t_dp_cmd  i_cmd,
    output wsfd_pkg::t_dp_stat o_stat,
    output wsfd_pkg::t_out     o_out
);
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_UPGRADE, PH_HEADER, PH_PAYLOAD, PH_HUNT, PH_HALTED
    } t_phase;

    logic [30:0] r_max;
    t_in         r_in;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_rmc, n_rmc;
    logic        r_rpo, n_rpo;
    logic [23:0] r_tw, n_tw;
    logic [3:0]  r_op, n_op;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_hbc, n_hbc;
    logic [31:0] r_mask, n_mask;
    logic [30:0] r_rem, n_rem;
    logic [1:0]  r_mpos, n_mpos;
    logic [7:0]  r_held [HOLD_DEPTH];
    logic [7:0]  n_held [HOLD_DEPTH];
    logic [7:0]  r_q [HOLD_DEPTH];
    logic [7:0]  n_q [HOLD_DEPTH];
    logic [3:0]  r_qcnt, n_qcnt;
    t_out        r_pend;
    t_out        r_out;

    logic [7:0]  b;
    logic        restart;
    logic [7:0]  q_rest [HOLD_DEPTH];
    logic [3:0]  rest_cnt;
    logic        hdr;
    logic        fdone;
    logic [3:0]  hb0;
    logic [63:0] len0, len_a, len_b;
    logic [31:0] mask0, mask_b;
    logic [3:0]  hc1;
    logic [6:0]  code;
    logic [3:0]  len_end;
    logic        found;
    logic [3:0]  k;
    logic [3:0]  m1;
    logic [4:0]  hidx;
    logic [3:0]  ridx;
    logic [7:0]  key;
    logic        match_ok;
    logic        term_end;
    logic        emit;
    t_out        res;

    assign b       = i_cmd.first ? r_in.rx_byte : r_q[0];
    assign restart = i_cmd.first && r_in.kind;

    always_comb begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            if (!i_cmd.first && i < HOLD_DEPTH - 1) begin
                q_rest[i] = r_q[i + 1];
            end else begin
                q_rest[i] = r_q[i];
            end
        end
        rest_cnt = i_cmd.first ? r_qcnt : r_qcnt - 4'd1;
    end

    always_comb begin
        n_phase  = r_phase;
        n_rmc    = r_rmc;
        n_rpo    = r_rpo;
        n_tw     = r_tw;
        n_op     = r_op;
        n_masked = r_masked;
        n_len    = r_len;
        n_hbc    = r_hbc;
        n_mask   = r_mask;
        n_rem    = r_rem;
        n_mpos   = r_mpos;
        n_held   = r_held;
        n_q      = q_rest;
        n_qcnt   = rest_cnt;
        hdr      = 1'b0;
        fdone    = 1'b0;
        hb0      = r_hbc;
        len0     = r_len;
        mask0    = r_mask;
        hc1      = '0;
        code     = '0;
        len_end  = '0;
        len_a    = '0;
        len_b    = '0;
        mask_b   = '0;
        found    = 1'b0;
        k        = '0;
        m1       = '0;
        hidx     = '0;
        ridx     = '0;
        key      = '0;
        match_ok = 1'b0;
        term_end = 1'b0;
        emit     = 1'b0;
        res      = '0;

        unique case (r_phase)
            PH_UPGRADE: begin
                term_end = (r_tw == 24'h0d0a0d) && (b == 8'h0a);
                if (r_rmc < 4'd12) begin
                    match_ok = (b == reply_char(r_rmc)) || (r_rmc == 4'd7 && b == 8'h30);
                    if (!match_ok) begin
                        n_rpo = 1'b0;
                    end
                    n_rmc = r_rmc + 4'd1;
                end
                n_tw = {r_tw[15:0], b};
                if (term_end) begin
                    emit = 1'b1;
                    if (n_rpo && n_rmc == 4'd12) begin
                        res.event_res = EV_UPGRADE_OK;
                        n_phase = PH_HEADER;
                        n_hbc   = '0;
                        n_len   = '0;
                        n_mask  = '0;
                        n_mpos  = '0;
                    end else begin
                        res.event_res = EV_UPGRADE_REJ;
                        n_phase = PH_HALTED;
                    end
                end
            end
            PH_HEADER: begin
                hdr = 1'b1;
            end
            PH_PAYLOAD: begin
                if (r_masked) begin
                    case (r_mpos)
                        2'd0:    key = r_mask[31:24];
                        2'd1:    key = r_mask[23:16];
                        2'd2:    key = r_mask[15:8];
                        default: key = r_mask[7:0];
                    endcase
                end
                n_mpos = r_mpos + 2'd1;
                n_rem  = r_rem - 31'd1;
                res.payload_byte   = b ^ key;
                res.frame_end      = (n_rem == '0);
                res.payload_length = r_len[30:0];
                if (r_op == OP_BINARY) begin
                    emit = 1'b1;
                    res.event_res = EV_DATA;
                end else if (r_op == OP_PING) begin
                    emit = 1'b1;
                    res.event_res = EV_PING;
                end
                fdone = (n_rem == '0);
            end
            PH_HUNT: begin
                if (b[3:0] == 4'h2) begin
                    hdr     = 1'b1;
                    hb0     = '0;
                    len0    = '0;
                    mask0   = '0;
                    n_mpos  = '0;
                    n_phase = PH_HEADER;
                end
            end
            PH_HALTED: begin
            end
            default: n_phase = PH_HALTED;
        endcase

        if (hdr) begin
            if (hb0 < 4'(HOLD_DEPTH)) begin
                n_held[hb0] = b;
            end
            hc1   = hb0 + 4'd1;
            n_hbc = hc1;
            n_len = len0;
            n_mask = mask0;
            if (hc1 == 4'd1) begin
                n_op = b[3:0];
            end else begin
                if (hc1 == 4'd2) begin
                    n_masked = b[7];
                    len_a = (b[6:0] < 7'd126) ? {57'd0, b[6:0]} : '0;
                end else begin
                    len_a = len0;
                end
                code = n_held[1][6:0];
                if (code < 7'd126) begin
                    len_end = 4'd2;
                end else if (code == 7'd126) begin
                    len_end = 4'd4;
                end else begin
                    len_end = 4'd10;
                end
                len_b  = len_a;
                mask_b = mask0;
                if (hc1 > 4'd2 && hc1 <= len_end) begin
                    len_b = {len_a[55:0], b};
                end else if (hc1 > len_end) begin
                    mask_b = {mask0[23:0], b};
                end
                n_len  = len_b;
                n_mask = mask_b;
                if (hc1 == len_end && len_b > {33'd0, r_max}) begin
                    emit = 1'b1;
                    res.event_res = EV_RESYNC;
                    n_hbc  = '0;
                    n_len  = '0;
                    n_mask = '0;
                    n_mpos = '0;
                    for (int i = 1; i < HOLD_DEPTH; i++) begin
                        if (!found && 4'(i) < hc1 && n_held[i][3:0] == 4'h2) begin
                            found = 1'b1;
                            k     = 4'(i);
                        end
                    end
                    if (!found) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = PH_HEADER;
                        m1 = hc1 - k;
                        for (int i = 0; i < HOLD_DEPTH; i++) begin
                            hidx = {1'b0, k} + 5'(i);
                            ridx = 4'(i) - m1;
                            if (4'(i) < m1) begin
                                n_q[i] = n_held[hidx[3:0]];
                            end else if (ridx < 4'(HOLD_DEPTH)) begin
                                n_q[i] = q_rest[ridx];
                            end else begin
                                n_q[i] = '0;
                            end
                        end
                        n_qcnt = m1 + rest_cnt;
                    end
                end else if (hc1 == len_end + (n_masked ? 4'd4 : 4'd0)) begin
                    n_rem  = len_b[30:0];
                    n_mpos = '0;
                    if (len_b[30:0] == '0) begin
                        res.frame_end = 1'b1;
                        if (r_op == OP_BINARY) begin
                            emit = 1'b1;
                            res.event_res = EV_EMPTY_BIN;
                        end else if (r_op == OP_PING) begin
                            emit = 1'b1;
                            res.event_res = EV_EMPTY_PING;
                        end
                        fdone = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        end

        if (fdone) begin
            if (r_op == OP_CLOSE) begin
                emit = 1'b1;
                res.event_res      = EV_CLOSE;
                res.payload_byte   = '0;
                res.frame_end      = 1'b1;
                res.payload_length = n_len[30:0];
                n_phase = PH_HALTED;
            end else begin
                n_phase = PH_HEADER;
                n_hbc   = '0;
                n_len   = '0;
                n_mask  = '0;
                n_mpos  = '0;
            end
        end

        if (restart) begin
            emit     = 1'b0;
            n_phase  = PH_UPGRADE;
            n_rmc    = '0;
            n_rpo    = 1'b1;
            n_tw     = '0;
            n_op     = '0;
            n_masked = 1'b0;
            n_len    = '0;
            n_hbc    = '0;
            n_mask   = '0;
            n_rem    = '0;
            n_mpos   = '0;
            n_qcnt   = '0;
        end
    end

    assign o_stat.emit = emit;
    assign o_stat.more = (n_qcnt != '0);
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= MAX_PAYLOAD_RESET;
            r_phase  <= PH_UPGRADE;
            r_rmc    <= '0;
            r_rpo    <= 1'b1;
            r_tw     <= '0;
            r_op     <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_hbc    <= '0;
            r_mask   <= '0;
            r_rem    <= '0;
            r_mpos   <= '0;
            r_qcnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.step) begin
                r_phase  <= n_phase;
                r_rmc    <= n_rmc;
                r_rpo    <= n_rpo;
                r_tw     <= n_tw;
                r_op     <= n_op;
                r_masked <= n_masked;
                r_len    <= n_len;
                r_hbc    <= n_hbc;
                r_mask   <= n_mask;
                r_rem    <= n_rem;
                r_mpos   <= n_mpos;
                r_qcnt   <= n_qcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.step) begin
            r_held <= n_held;
            r_q    <= n_q;
        end
        if (i_cmd.p_load) begin
            r_pend <= res;
        end
        if (i_cmd.o_load) begin
            r_out          <= r_pend;
            r_out.run_last <= i_cmd.o_last;
        end
    end

endmodule

/* design/websocket_frame_decoder.sv */
// Each result waits in the single pending result register until the next result of its item,
// or the end of the item, moves it to the output register; a stalled output holds it there.
// A new item is taken only when idle, after the item's byte and any header bytes replayed
// after a resync have passed the per-byte decoder step and the last result has been flushed,
// so the block cannot take a new item before it is through with the last one.
// Reset is synchronous and active low; it restores the upgrade wait and the length limit.
module websocket_frame_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wsfd_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wsfd_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [30:0]    i_cfg_data
);
    import wsfd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    wsfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    wsfd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out       (o_out)
    );

endmodule

/* design/wsfd_checker.sv */
`include "assert_macros.svh"

module wsfd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input wsfd_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input wsfd_pkg::t_out o_out
);
    import wsfd_pkg::*;

    `WSFD_CHK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "output item dropped or changed while stalled")
    `WSFD_CHK(a_item_open, o_out_valid && !o_out.run_last |-> !o_in_ready, "new item accepted before the previous one finished")
    `WSFD_CHK(a_restart_quiet, i_in_valid && o_in_ready && i_in.kind |=> !$rose(o_out_valid), "restart produced an output item")
    `WSFD_CHK(a_status_fields, o_out_valid && (o_out.event_res == EV_UPGRADE_OK || o_out.event_res == EV_UPGRADE_REJ || o_out.event_res == EV_RESYNC) |-> o_out.payload_length == '0 && !o_out.frame_end, "status event carries frame fields")
    `WSFD_CHK_RST(a_reset_idle, !i_rst_n |=> !o_out_valid && o_in_ready, "block not idle after reset")

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
